### rtl/interval_capacity_reservation_top_assert.svh
// Assertion macros shared by the interval capacity reservation RTL.
// Expects signals named clk and arst_n in the including module.
`ifndef INTERVAL_CAPACITY_RESERVATION_TOP_ASSERT_SVH
`define INTERVAL_CAPACITY_RESERVATION_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define ICR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent
`define ICR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/icr_pkg.sv
// Package for the interval capacity reservation block: sizes, reset values,
// request and result structs. No dependencies.
`default_nettype none

package icr_pkg;

	localparam int SLOTS     = 2048;
	localparam int ADDR_W    = $clog2(SLOTS);
	localparam int SLOT_W    = 11;
	localparam int LOAD_W    = 16;
	localparam int SUM_W     = 32;
	localparam int CNT_W     = ((ADDR_W >= SLOT_W) ? ADDR_W : SLOT_W) + 1;
	localparam int CAP_RESET = 65535;

	// Request as taken from the input stream
	typedef struct packed {
		logic [LOAD_W-1:0] amount;
		logic [SLOT_W-1:0] end_slot;
		logic [SLOT_W-1:0] first_slot;
	} req_t;

	// Result handed to the output register
	typedef struct packed {
		logic              malformed;
		logic [SUM_W-1:0]  total_granted;
		logic [LOAD_W-1:0] granted;
	} res_t;

endpackage

`default_nettype wire

### rtl/icr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module icr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/icr_engine.sv
// Reservation engine: clears the slot RAM, scans a span for its peak load,
// grants and writes the span back. Uses icr_pkg, icr_ram and the assert macros.
`default_nettype none
`include "interval_capacity_reservation_top_assert.svh"

module icr_engine
	import icr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [LOAD_W-1:0] cap,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_t              req,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res
);

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_SCAN, ST_SCAN_LAST,
		ST_DECIDE, ST_FILL, ST_FILL_LAST, ST_DONE
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic [ADDR_W-1:0] last_q;
	logic [ADDR_W-1:0] lo_q;
	logic [LOAD_W-1:0] amt_q;
	logic [LOAD_W-1:0] peak_q;
	logic [LOAD_W-1:0] grant_q;
	logic              malformed_q;
	logic [SUM_W-1:0]  sum_q;
	logic              rd_vld_s1;
	logic              wb_s1;
	logic [ADDR_W-1:0] wb_addr_s1;

	logic [CNT_W-1:0]  req_lo_c;
	logic [CNT_W-1:0]  req_end_c;
	logic [CNT_W-1:0]  stop_c;
	logic              bad_c;
	logic              empty_c;
	logic              accept_c;
	logic [LOAD_W-1:0] room_c;
	logic [LOAD_W-1:0] grant_c;
	logic [SUM_W:0]    sum_add_c;
	logic [SUM_W-1:0]  sum_nxt_c;

	logic              ram_re;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [LOAD_W-1:0] ram_wdata;
	logic [LOAD_W-1:0] ram_rdata;

	// span decode of the incoming request, cut at the end of the timeline
	always_comb begin
		req_lo_c  = CNT_W'(req.first_slot);
		req_end_c = CNT_W'(req.end_slot);
		stop_c    = (req_end_c > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : req_end_c;
		bad_c     = (req.end_slot <= req.first_slot);
		empty_c   = (req_lo_c >= stop_c);
	end

	assign req_ready = (state_q == ST_IDLE);
	assign accept_c  = req_valid && req_ready;

	// grant from the peak: min(amount, capacity - peak), zero when full
	always_comb begin
		room_c  = cap - peak_q;
		if (peak_q < cap) begin
			grant_c = (amt_q < room_c) ? amt_q : room_c;
		end else begin
			grant_c = '0;
		end
	end

	// saturating running total
	always_comb begin
		sum_add_c = {1'b0, sum_q} + (SUM_W+1)'(grant_q);
		sum_nxt_c = sum_add_c[SUM_W] ? '1 : sum_add_c[SUM_W-1:0];
	end

	// RAM access: reads for the scan and fill walks; writes for the clear sweep or the write-back behind the fill read
	assign ram_re    = (state_q == ST_SCAN) || (state_q == ST_FILL);
	assign ram_we    = (state_q == ST_CLEAR) || wb_s1;
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : wb_addr_s1;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : ram_rdata + grant_q;

	icr_ram #(
		.WIDTH (LOAD_W),
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			rd_vld_s1 <= 1'b0;
			wb_s1     <= 1'b0;
			sum_q     <= '0;
		end else begin
			rd_vld_s1 <= ram_re;
			wb_s1     <= (state_q == ST_FILL);
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept_c) begin
						state_q <= (bad_c || empty_c) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_addr_q == last_q) begin
						state_q <= ST_SCAN_LAST;
					end
				end
				ST_SCAN_LAST: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= (grant_c == '0) ? ST_DONE : ST_FILL;
				end
				ST_FILL: begin
					if (rd_addr_q == last_q) begin
						state_q <= ST_FILL_LAST;
					end
				end
				ST_FILL_LAST: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						sum_q   <= sum_nxt_c;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload, address walk and peak tracking
	always_ff @(posedge clk) begin
		wb_addr_s1 <= rd_addr_q;
		if (accept_c) begin
			lo_q        <= ADDR_W'(req.first_slot);
			rd_addr_q   <= ADDR_W'(req.first_slot);
			last_q      <= ADDR_W'(stop_c - 1'b1);
			amt_q       <= req.amount;
			malformed_q <= bad_c;
			peak_q      <= '0;
			grant_q     <= '0;
		end else if (ram_re) begin
			rd_addr_q <= rd_addr_q + 1'b1;
		end else if (state_q == ST_DECIDE) begin
			grant_q   <= grant_c;
			rd_addr_q <= lo_q;
		end
		if (rd_vld_s1 && !wb_s1 && (ram_rdata > peak_q)) begin
			peak_q <= ram_rdata;
		end
	end

	assign res_valid         = (state_q == ST_DONE);
	assign res.granted       = grant_q;
	assign res.total_granted = sum_nxt_c;
	assign res.malformed     = malformed_q;

	`ICR_ASSERT_NOW(a_no_rw_collide, ram_re && ram_we, rd_addr_q != ram_waddr,
		"slot RAM read and written at the same address")
	`ICR_ASSERT_NOW(a_grant_in_cap, state_q == ST_DONE, grant_q <= cap,
		"grant exceeds capacity")
	`ICR_ASSERT_NEXT(a_sum_monotonic, 1'b1, sum_q >= $past(sum_q),
		"running total decreased")
	`ICR_ASSERT_NEXT(a_done_to_idle, res_valid && res_ready, state_q == ST_IDLE,
		"engine did not return to idle after handing over a result")

endmodule

`default_nettype wire

### rtl/interval_capacity_reservation_top.sv
// Top level of the interval capacity reservation block: stream ports, capacity
// register and output register. Uses icr_pkg and icr_engine.
//
//   channel   dir  fields
//   s_axis    in   tdata: first_slot[10:0], end_slot[21:11], amount[37:22]
//   m_axis    out  tdata: granted[15:0], total_granted[47:16]; tuser: malformed
//   cfg       in   cfg_wdata: capacity[15:0], written when cfg_wen is high
//
// After reset the slot RAM is cleared address by address; s_axis_tready stays low until that is done.
// A request over n slots walks the single RAM read port over its span twice, once
// for the peak and once for the write-back. A request refused at the peak walks it
// once only; a malformed or empty one reads no slot.
// The output register lets the next request start while a result is stalled.
`default_nettype none

module interval_capacity_reservation_top
	import icr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,     // capacity[15:0]
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // first_slot[10:0], end_slot[21:11], amount[37:22]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // granted[15:0], total_granted[47:16]
	output logic [0:0]  m_axis_tuser   // malformed[0]
);

	logic [LOAD_W-1:0] cap_q;
	logic              out_vld_q;
	res_t              out_res_q;
	req_t              req;
	logic              res_valid;
	logic              res_ready;
	res_t              res;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= LOAD_W'(CAP_RESET);
		end else if (cfg_wen) begin
			cap_q <= cfg_wdata;
		end
	end

	// unpack the input transaction
	assign req.first_slot = s_axis_tdata[10:0];
	assign req.end_slot   = s_axis_tdata[21:11];
	assign req.amount     = s_axis_tdata[37:22];

	icr_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cap       (cap_q),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register
	assign res_ready = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_res_q.total_granted, out_res_q.granted};
	assign m_axis_tuser  = out_res_q.malformed;

endmodule

`default_nettype wire

### sim/interval_capacity_reservation_top_tb.sv
// Self-checking bench for interval_capacity_reservation_top: span requests are streamed
// in, grants are predicted from a local copy of the slot loads and checked per transaction.
// Depends on icr_pkg and the RTL top level only.
`default_nettype none

module interval_capacity_reservation_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import icr_pkg::*;

	localparam int HOLD_CYCLES = 10000;
	localparam int TAIL_CYCLES = 100;
	localparam int PHASE_ITEMS = 40;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_wen       = 1'b0;
	logic [15:0] cfg_wdata     = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata  = '0;  // first_slot[10:0], end_slot[21:11], amount[37:22]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;        // granted[15:0], total_granted[47:16]
	logic [0:0]  m_axis_tuser;        // malformed[0]

	// Bench state: pending requests, grants still due, local slot loads
	req_t        request_queue[$];
	res_t        grants_due[$];
	res_t        seen_grant;
	res_t        due_grant;
	logic [15:0] slot_load_copy[SLOTS];
	logic [31:0] grant_total   = '0;
	logic [15:0] capacity_now  = 16'(CAP_RESET);

	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;
	int accept_count   = 0;
	int offer_mark     = 0;
	int hold_left      = 0;
	bit hold_done      = 1'b0;
	int hold_arm_at    = 32'h7fff_ffff;
	int stall_cycles   = 0;
	int cycle_count    = 0;
	int cycle_budget   = 4 * SLOTS + 20000 + HOLD_CYCLES;
	int mismatches     = 0;
	int malformed_seen = 0;
	int zero_grants    = 0;
	int cap_writes     = 0;

	interval_capacity_reservation_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Greedy admission: peak over [first, end), grant what fits, load the span
	task automatic reserve_span(input req_t r);
		res_t        due;
		int          lo;
		int          hi;
		logic [15:0] peak;
		logic [15:0] room;
		logic [15:0] grant;
		logic [32:0] wide_sum;
		lo = r.first_slot;
		hi = r.end_slot;
		grant = '0;
		due.malformed = 1'b0;
		if (hi <= lo) begin
			due.malformed = 1'b1;
			malformed_seen++;
		end else begin
			if (hi > SLOTS)
				hi = SLOTS;
			peak = '0;
			for (int j = lo; j < hi; j++)
				if (slot_load_copy[j] > peak)
					peak = slot_load_copy[j];
			if (peak < capacity_now) begin
				room = capacity_now - peak;
				grant = (r.amount < room) ? r.amount : room;
				for (int j = lo; j < hi; j++)
					slot_load_copy[j] = slot_load_copy[j] + grant;
			end
			if (grant == 0)
				zero_grants++;
		end
		// running total sticks at all ones
		wide_sum = {1'b0, grant_total} + 33'(grant);
		grant_total = wide_sum[32] ? '1 : wide_sum[31:0];
		due.granted = grant;
		due.total_granted = grant_total;
		grants_due.insert(grants_due.size(), due);
	endtask

	// Accepted input transaction: predict, retire from the pending queue; else count input stalls under the hold-off
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			reserve_span(req_t'(s_axis_tdata[37:0]));
			void'(request_queue.pop_front());
			accept_count++;
		end else if (hold_left != 0 && s_axis_tvalid && !s_axis_tready) begin
			stall_cycles++;
		end
	end

	// Driver and receiver: change on the falling edge, offer held until taken
	always @(negedge clk) begin
		if (!(s_axis_tvalid && accept_count == offer_mark)) begin
			if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {2'b00, request_queue[0]};
				offer_mark    <= accept_count;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
	end

	// Long output hold-off, armed once by the stimulus
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && accept_count >= hold_arm_at) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Result monitor: compare against the oldest grant due
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_grant.granted       = m_axis_tdata[15:0];
			seen_grant.total_granted = m_axis_tdata[47:16];
			seen_grant.malformed     = m_axis_tuser[0];
			if (grants_due.size() == 0) begin
				$error("result with no request outstanding: granted %0d total %0d",
					seen_grant.granted, seen_grant.total_granted);
				mismatches++;
			end else begin
				due_grant = grants_due.pop_front();
				if (seen_grant.granted !== due_grant.granted) begin
					$error("granted: expected %0d, got %0d",
						due_grant.granted, seen_grant.granted);
					mismatches++;
				end
				if (seen_grant.total_granted !== due_grant.total_granted) begin
					$error("total_granted: expected %0d, got %0d",
						due_grant.total_granted, seen_grant.total_granted);
					mismatches++;
				end
				if (seen_grant.malformed !== due_grant.malformed) begin
					$error("malformed: expected %0d, got %0d",
						due_grant.malformed, seen_grant.malformed);
					mismatches++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > cycle_budget) begin
			$display("** interval_capacity_reservation_top: FAILED **");
			$finish;
		end
	end

	task automatic queue_request(input int first, input int stop, input int amount);
		req_t r;
		int   span;
		r.first_slot = 11'(first);
		r.end_slot   = 11'(stop);
		r.amount     = 16'(amount);
		span = (stop > first) ? stop - first : 0;
		cycle_budget += 4 * (2 * span + 64);
		request_queue.insert(request_queue.size(), r);
	endtask

	// Wait until every request has been taken and answered
	task automatic settle();
		while (request_queue.size() != 0 || grants_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] value);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wen <= 1'b0;
		capacity_now = value;
		cap_writes++;
		cycle_budget += 50;
	endtask

	// Mostly short spans, just under half of them crowded at the low end for contention, plus reversed and long ones
	task automatic random_phase(input int n_items);
		int kind;
		int first;
		int stop;
		int len;
		int pick;
		int amount;
		for (int i = 0; i < n_items; i++) begin
			kind = $urandom_range(0, 19);
			if (kind < 2) begin
				first = $urandom_range(0, 2047);
				stop  = $urandom_range(0, first);
			end else if (kind == 2) begin
				first = $urandom_range(0, 300);
				stop  = $urandom_range(1700, 2047);
			end else begin
				len   = $urandom_range(1, 48);
				first = (kind < 11) ? $urandom_range(0, 200) : $urandom_range(0, 2047 - len);
				stop  = first + len;
			end
			pick = $urandom_range(0, 9);
			case (pick)
				0:       amount = 0;
				1:       amount = 65535;
				2, 3:    amount = $urandom_range(0, 65535);
				default: amount = $urandom_range(1, 6000);
			endcase
			queue_request(first, stop, amount);
		end
	endtask

	initial begin
		for (int j = 0; j < SLOTS; j++)
			slot_load_copy[j] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 34;
		recv_idle_pct = 83;

		// Directed: reset capacity, extremes of every field, refused and reversed spans
		queue_request(0, 2047, 0);
		queue_request(0, 1, 65535);
		queue_request(0, 2, 7);
		queue_request(1, 3, 40000);
		queue_request(2, 4, 30000);
		queue_request(2046, 2047, 65535);
		queue_request(2047, 2047, 100);
		queue_request(2047, 0, 65535);
		queue_request(10, 10, 5);
		queue_request(1500, 1499, 1);
		queue_request(1000, 2047, 1234);
		settle();

		// Capacity lowered below existing loads, then the minimum
		write_capacity(16'd1);
		queue_request(3, 4, 10);
		queue_request(100, 101, 65535);
		queue_request(100, 102, 1);
		queue_request(101, 103, 0);
		settle();

		write_capacity(16'd0);
		queue_request(200, 210, 500);
		queue_request(300, 300, 1);
		settle();

		// Random, sender idling at times and receiver mostly stalled
		write_capacity(16'hFFFF);
		random_phase(PHASE_ITEMS);
		settle();

		// Random, roles swapped, mid-range capacity
		send_idle_pct = 83;
		recv_idle_pct = 34;
		write_capacity(16'($urandom_range(1000, 50000)));
		random_phase(PHASE_ITEMS);
		settle();

		// Random, no idling, with one long output hold-off
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_capacity(16'($urandom_range(40000, 65535)));
		hold_arm_at = accept_count + 6;
		random_phase(PHASE_ITEMS);
		settle();

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d span requests (%0d reversed or empty, %0d well-formed with no grant)",
			accept_count, malformed_seen, zero_grants - 0);
		$display("over %0d capacity settings; input stalled %0d cycles under output hold-off",
			cap_writes + 1, stall_cycles);
		if (mismatches == 0) begin
			$display("** interval_capacity_reservation_top: PASSED **");
		end else begin
			$display("** interval_capacity_reservation_top: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire

### interval_capacity_reservation_top.f
+incdir+rtl
rtl/icr_pkg.sv
rtl/icr_ram.sv
rtl/icr_engine.sv
rtl/interval_capacity_reservation_top.sv
sim/interval_capacity_reservation_top_tb.sv
